// ===== rtl/qsc_pkg.sv =====
package qsc_pkg;

    localparam int unsigned ValueW   = 9;
    localparam int unsigned StepW    = 8;
    localparam int unsigned TickW    = 16;
    localparam int unsigned SetW     = 10;
    localparam int unsigned CfgDataW = 16;

    localparam logic [ValueW-1:0] ResetValue   = 9'd120;
    localparam logic [ValueW-1:0] ResetMin     = 9'd40;
    localparam logic [ValueW-1:0] ResetMax     = 9'd300;
    localparam logic [StepW-1:0]  ResetStep    = 8'd5;
    localparam logic [TickW-1:0]  ResetHoldoff = 16'd150;
    localparam logic [TickW-1:0]  TickSat      = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_EDGE = 2'd0,
        OP_TICK = 2'd1,
        OP_SET  = 2'd2
    } qsc_op_t;

    typedef enum logic [1:0] {
        MOVED_NONE = 2'd0,
        MOVED_UP   = 2'd1,
        MOVED_DOWN = 2'd2
    } qsc_moved_t;

    typedef enum logic [1:0] {
        REG_MIN_VALUE     = 2'd0,
        REG_MAX_VALUE     = 2'd1,
        REG_STEP_SIZE     = 2'd2,
        REG_HOLDOFF_TICKS = 2'd3
    } qsc_reg_t;

    typedef struct packed {
        logic [1:0]      op;
        logic            from_line_a;
        logic            rising;
        logic [SetW-1:0] set_value;
    } qsc_item_t;

    typedef struct packed {
        logic [ValueW-1:0] value;
        logic [1:0]        moved;
    } qsc_result_t;

endpackage

// ===== rtl/quadrature_step_counter.sv =====
// Quadrature step counter: decodes encoder edge items into a clamped counter value.
// Each result is registered in the output entry, or in the skid entry while that one stalls.
// Throughput: one item per cycle; a two-entry output stage lets input continue while
// a result waits, and s_axis_tready drops only when both entries hold results.
// Reset (rst_n low, asynchronous): value 120, limits 40..300, step 5, holdoff 150,
// levels low, first edge pending, tick count zero, output stage empty.
module quadrature_step_counter
    import qsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,  // from_line_a, rising, set_value[9:0], zero pad
    input  logic [1:0]          s_axis_tuser,  // op
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,  // value[8:0], zero pad
    output logic [1:0]          m_axis_tuser,  // moved
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    qsc_item_t   item;
    qsc_result_t result;
    logic        in_accept;
    logic        out_accept;

    qsc_result_t out_reg;
    logic        out_valid_reg;
    qsc_result_t skid_reg;
    logic        skid_valid_reg;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_accept    = out_valid_reg && m_axis_tready;

    assign item.op          = s_axis_tuser;
    assign item.from_line_a = s_axis_tdata[0];
    assign item.rising      = s_axis_tdata[1];
    assign item.set_value   = s_axis_tdata[SetW+1:2];

    qsc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_accept (in_accept),
        .item        (item),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_accept && (!out_valid_reg || out_accept))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
        else if (out_accept)
        begin
            // refill from the skid entry, otherwise drain
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (!out_valid_reg || out_accept))
        begin
            out_reg <= result;
        end
        else if (in_accept)
        begin
            skid_reg <= result;
        end
        else if (out_accept && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(16-ValueW){1'b0}}, out_reg.value};
    assign m_axis_tuser  = out_reg.moved;

endmodule

// ===== rtl/qsc_core.sv =====
module qsc_core
    import qsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    input  logic                item_accept,
    input  qsc_item_t           item,
    output qsc_result_t         result
);

    logic [ValueW-1:0] min_value_reg;
    logic [ValueW-1:0] max_value_reg;
    logic [StepW-1:0]  step_size_reg;
    logic [TickW-1:0]  holdoff_ticks_reg;

    logic              level_a_reg, level_a_next;
    logic              level_b_reg, level_b_next;
    logic              first_edge_reg, first_edge_next;
    logic [TickW-1:0]  ticks_reg, ticks_next;
    logic [ValueW-1:0] count_reg, count_next;
    logic [1:0]        moved;

    logic [ValueW:0]   sum_up;
    logic [ValueW-1:0] up_val;
    logic [ValueW-1:0] diff_down;
    logic              underflow;
    logic [ValueW-1:0] down_val;
    logic [ValueW-1:0] set_val;

    always_comb
    begin
        sum_up    = {1'b0, count_reg} + {2'b00, step_size_reg};
        up_val    = (sum_up > {1'b0, max_value_reg}) ? max_value_reg : sum_up[ValueW-1:0];
        diff_down = count_reg - {1'b0, step_size_reg};
        underflow = count_reg < {1'b0, step_size_reg};
        down_val  = (underflow || (diff_down < min_value_reg)) ? min_value_reg : diff_down;
        if (item.set_value < {1'b0, min_value_reg})
        begin
            set_val = min_value_reg;
        end
        else if (item.set_value > {1'b0, max_value_reg})
        begin
            set_val = max_value_reg;
        end
        else
        begin
            set_val = item.set_value[ValueW-1:0];
        end
    end

    always_comb
    begin
        level_a_next    = level_a_reg;
        level_b_next    = level_b_reg;
        first_edge_next = first_edge_reg;
        ticks_next      = ticks_reg;
        count_next      = count_reg;
        moved           = MOVED_NONE;
        case (item.op)
            OP_EDGE:
            begin
                if (item.from_line_a)
                begin
                    level_a_next = item.rising;
                end
                else
                begin
                    level_b_next = item.rising;
                end
                if (first_edge_reg)
                begin
                    first_edge_next = 1'b0;
                end
                else if (ticks_reg >= holdoff_ticks_reg)
                begin
                    // falling A with B high steps up, falling B with A high steps down
                    if (item.from_line_a && !item.rising && level_b_reg)
                    begin
                        count_next = up_val;
                        ticks_next = '0;
                        moved      = MOVED_UP;
                    end
                    else if (!item.from_line_a && !item.rising && level_a_reg)
                    begin
                        count_next = down_val;
                        ticks_next = '0;
                        moved      = MOVED_DOWN;
                    end
                end
            end
            OP_TICK:
            begin
                if (ticks_reg != TickSat)
                begin
                    ticks_next = ticks_reg + 1'b1;
                end
            end
            OP_SET:
            begin
                count_next = set_val;
            end
            default:
            begin
                moved = MOVED_NONE;
            end
        endcase
        result.value = count_next;
        result.moved = moved;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_value_reg     <= ResetMin;
            max_value_reg     <= ResetMax;
            step_size_reg     <= ResetStep;
            holdoff_ticks_reg <= ResetHoldoff;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MIN_VALUE:     min_value_reg     <= cfg_data[ValueW-1:0];
                REG_MAX_VALUE:     max_value_reg     <= cfg_data[ValueW-1:0];
                REG_STEP_SIZE:     step_size_reg     <= cfg_data[StepW-1:0];
                REG_HOLDOFF_TICKS: holdoff_ticks_reg <= cfg_data[TickW-1:0];
                default:           min_value_reg     <= min_value_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_a_reg    <= 1'b0;
            level_b_reg    <= 1'b0;
            first_edge_reg <= 1'b1;
            ticks_reg      <= '0;
            count_reg      <= ResetValue;
        end
        else if (item_accept)
        begin
            level_a_reg    <= level_a_next;
            level_b_reg    <= level_b_next;
            first_edge_reg <= first_edge_next;
            ticks_reg      <= ticks_next;
            count_reg      <= count_next;
        end
    end

endmodule

// ===== rtl/qsc_checker.sv =====
module qsc_checker
    import qsc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted item gave no result");

    // input stalls only when a result is waiting
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    a_stall_persists: assert property (@(posedge clk) disable iff (!rst_n)
        (!s_axis_tready && !m_axis_tready) |=> !s_axis_tready)
        else $error("input freed without output drain");

    a_moved_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == MOVED_NONE || m_axis_tuser == MOVED_UP ||
                           m_axis_tuser == MOVED_DOWN))
        else $error("bad moved code");

endmodule

bind quadrature_step_counter qsc_checker u_qsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== bench/quadrature_step_counter_test.sv =====
`timescale 1ns / 1ps

module quadrature_step_counter_test;
    import qsc_pkg::*;

    localparam logic [1:0] OpReserved = 2'd3;
    localparam int SettleCycles = 4;
    localparam int HoldCycles   = 300;
    localparam int StallLimit   = 2000;
    localparam int PhaseItems   = 92;

    logic clk = 1'b0;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [15:0] s_axis_tdata;  // from_line_a, rising, set_value[9:0], zero pad
    logic [1:0] s_axis_tuser;   // op
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [15:0] m_axis_tdata;  // value[8:0], zero pad
    logic [1:0] m_axis_tuser;   // moved
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    // counter copy kept by the bench
    logic [ValueW-1:0] lo_lim;
    logic [ValueW-1:0] hi_lim;
    logic [StepW-1:0] step_amt;
    logic [TickW-1:0] holdoff;
    logic lvl_a;
    logic lvl_b;
    logic first_pending;
    logic [TickW-1:0] ticks;
    logic [ValueW-1:0] count;

    qsc_result_t awaited_readings[$];
    qsc_result_t want;
    int errors = 0;
    int items_sent = 0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    bit hold_req = 1'b0;

    quadrature_step_counter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic qsc_result_t advance_counter(input logic [1:0] op, input logic line_a,
                                                    input logic rise,
                                                    input logic [SetW-1:0] setv);
        qsc_result_t r;
        int v;
        r.moved = MOVED_NONE;
        case (op)
            OP_EDGE:
            begin
                if (line_a)
                    lvl_a = rise;
                else
                    lvl_b = rise;
                if (first_pending)
                    first_pending = 1'b0;
                else if (ticks >= holdoff)
                begin
                    if (line_a && !rise && lvl_b)
                    begin
                        v = int'(count) + int'(step_amt);
                        if (v > int'(hi_lim))
                            v = int'(hi_lim);
                        count = v[ValueW-1:0];
                        ticks = '0;
                        r.moved = MOVED_UP;
                    end
                    else if (!line_a && !rise && lvl_a)
                    begin
                        v = int'(count) - int'(step_amt);
                        if (v < int'(lo_lim))
                            v = int'(lo_lim);
                        count = v[ValueW-1:0];
                        ticks = '0;
                        r.moved = MOVED_DOWN;
                    end
                end
            end
            OP_TICK:
            begin
                if (ticks != TickSat)
                    ticks = ticks + 1'b1;
            end
            OP_SET:
            begin
                // lower limit is checked first, so it wins when the limits cross and both apply
                if (setv < lo_lim)
                    count = lo_lim;
                else if (setv > hi_lim)
                    count = hi_lim;
                else
                    count = setv[ValueW-1:0];
            end
            default:
            begin
            end
        endcase
        r.value = count;
        return r;
    endfunction

    task automatic offer_item(input logic [1:0] op, input logic line_a, input logic rise,
                              input logic [SetW-1:0] setv);
        int gap;
        gap = tx_quiet ? 0 : gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = op;
        s_axis_tdata = {4'b0, setv, rise, line_a};
        do
            @(posedge clk);
        while (!s_axis_tready);
        awaited_readings.push_back(advance_counter(op, line_a, rise, setv));
        items_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (awaited_readings.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(input qsc_reg_t idx, input logic [CfgDataW-1:0] data);
        drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MIN_VALUE:     lo_lim = data[ValueW-1:0];
            REG_MAX_VALUE:     hi_lim = data[ValueW-1:0];
            REG_STEP_SIZE:     step_amt = data[StepW-1:0];
            REG_HOLDOFF_TICKS: holdoff = data;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_limits(input int lo, input int hi, input int stp, input int hold);
        write_reg(REG_MIN_VALUE, CfgDataW'(lo));
        write_reg(REG_MAX_VALUE, CfgDataW'(hi));
        write_reg(REG_STEP_SIZE, CfgDataW'(stp));
        write_reg(REG_HOLDOFF_TICKS, CfgDataW'(hold));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) offer_item(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              SetW'($urandom_range(0, 1023)));
    endtask

    task automatic edge_item(input logic line_a, input logic rise);
        offer_item(OP_EDGE, line_a, rise, SetW'($urandom_range(0, 1023)));
    endtask

    // one detent: leading line rises, lagging rises, leading falls, lagging falls
    task automatic turn_detent(input bit clockwise);
        int k;
        int skip;
        skip = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : -1;
        for (k = 0; k < 4; k++)
        begin
            if (holdoff < 8)
                send_ticks($urandom_range(0, holdoff + 1));
            else
                send_ticks($urandom_range(0, 3));
            if (k != skip)
                edge_item((k % 2 == 0) ? clockwise : !clockwise, k < 2);
        end
    endtask

    task automatic test_reset_defaults();
        offer_item(OpReserved, 1'b1, 1'b1, 10'h3FF);
        offer_item(OP_SET, 1'b0, 1'b0, 10'd0);
        offer_item(OP_SET, 1'b0, 1'b0, 10'd1023);
        offer_item(OP_SET, 1'b0, 1'b0, 10'd170);
        edge_item(1'b0, 1'b1);
        // still inside the holdoff window
        edge_item(1'b1, 1'b0);
        send_ticks(150);
        edge_item(1'b1, 1'b1);
        edge_item(1'b1, 1'b0);
        edge_item(1'b0, 1'b0);
        edge_item(1'b1, 1'b1);
        send_ticks(149);
        edge_item(1'b0, 1'b1);
        edge_item(1'b0, 1'b0);
        send_ticks(1);
        edge_item(1'b0, 1'b1);
        edge_item(1'b0, 1'b0);
    endtask

    task automatic test_limits_and_steps();
        set_limits(0, 511, 255, 0);
        offer_item(OP_SET, 1'b1, 1'b1, 10'd1023);
        edge_item(1'b0, 1'b1);
        edge_item(1'b1, 1'b0);
        edge_item(1'b1, 1'b1);
        edge_item(1'b0, 1'b0);
        edge_item(1'b0, 1'b1);
        edge_item(1'b0, 1'b0);
        edge_item(1'b0, 1'b1);
        edge_item(1'b0, 1'b0);
        write_reg(REG_STEP_SIZE, 16'd1);
        edge_item(1'b0, 1'b1);
        edge_item(1'b1, 1'b0);
        edge_item(1'b1, 1'b0);
        // crossed limits: lower limit takes priority on a set
        set_limits(511, 0, 1, 0);
        offer_item(OP_SET, 1'b0, 1'b1, 10'd5);
        offer_item(OP_SET, 1'b1, 1'b0, 10'd1023);
        edge_item(1'b1, 1'b0);
        edge_item(1'b1, 1'b1);
        edge_item(1'b0, 1'b0);
        offer_item(OpReserved, 1'b0, 1'b0, 10'd0);
    endtask

    task automatic test_backpressure();
        int k;
        set_limits(10, 400, 3, 0);
        tx_quiet = 1'b1;
        hold_req = 1'b1;
        for (k = 0; k < 10; k++)
            turn_detent($urandom_range(0, 1));
        tx_quiet = 1'b0;
    endtask

    task automatic test_random_rotation();
        int phase;
        int start;
        int r;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_limits(0, 511, 255, 0);
                1: set_limits(0, 511, 1, 1);
                2: set_limits($urandom_range(300, 511), $urandom_range(0, 200),
                              $urandom_range(1, 20), $urandom_range(0, 3));
                3: set_limits($urandom_range(0, 200), $urandom_range(300, 511),
                              $urandom_range(1, 40), 65535);
                default: set_limits($urandom_range(0, 250), $urandom_range(250, 511),
                                    $urandom_range(1, 60), $urandom_range(0, 6));
            endcase
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            start = items_sent;
            while (items_sent - start < PhaseItems)
            begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    turn_detent($urandom_range(0, 1));
                else if (r == 7)
                    offer_item(OP_SET, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               SetW'($urandom_range(0, 1023)));
                else
                    offer_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), SetW'($urandom_range(0, 1023)));
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    task automatic test_long_holdoff();
        set_limits(0, 511, 7, 0);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        offer_item(OP_SET, 1'b0, 1'b0, 10'd100);
        // take one step to clear the tick count
        edge_item(1'b0, 1'b1);
        edge_item(1'b1, 1'b1);
        edge_item(1'b1, 1'b0);
        write_reg(REG_HOLDOFF_TICKS, 16'd200);
        send_ticks(199);
        edge_item(1'b1, 1'b1);
        edge_item(1'b1, 1'b0);
        send_ticks(1);
        edge_item(1'b1, 1'b1);
        edge_item(1'b1, 1'b0);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // receiver: random stalls plus one long hold on request
    initial
    begin : receiver
        int hold_left;
        int stall_left;
        hold_left = 0;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HoldCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready = 1'b0;
            end
            else
            begin
                m_axis_tready = 1'b1;
                if (!rx_quiet)
                    stall_left = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_readings.size() == 0)
            begin
                $error("unexpected item: value %0d moved %0d", m_axis_tdata[ValueW-1:0],
                       m_axis_tuser);
                errors++;
            end
            else
            begin
                want = awaited_readings.pop_front();
                if (m_axis_tdata[ValueW-1:0] !== want.value)
                begin
                    $error("value: expected %0d, got %0d", want.value,
                           m_axis_tdata[ValueW-1:0]);
                    errors++;
                end
                if (m_axis_tuser !== want.moved)
                begin
                    $error("moved: expected %0d, got %0d", want.moved, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < StallLimit)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        lo_lim = ResetMin;
        hi_lim = ResetMax;
        step_amt = ResetStep;
        holdoff = ResetHoldoff;
        lvl_a = 1'b0;
        lvl_b = 1'b0;
        first_pending = 1'b1;
        ticks = '0;
        count = ResetValue;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_limits_and_steps();
        test_backpressure();
        test_random_rotation();
        test_long_holdoff();

        drain();
        repeat (8) @(posedge clk);
        if (errors == 0 && awaited_readings.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
